// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/aesd_pkg.sv
// ----------------------------------------------------------------------------
// AES decrypt package
// S-box tables, GF helpers and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none
package aesd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEXP,
    ST_ROUND,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_IV_HIGH    = 3'd2,
    REG_IV_LOW     = 3'd3,
    REG_CHAIN_MODE = 3'd4
  } reg_idx_t;

  localparam int unsigned NUM_ROUNDS = 10;

  typedef logic [7:0] sbox_arr_t [256];

  localparam sbox_arr_t SBOX_FWD = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam sbox_arr_t SBOX_INV = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    v = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (i < int'(r)) v = xtime(v);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/aesd_round.sv
// ----------------------------------------------------------------------------
// AES decrypt round unit
// One inverse round: shift, inverse S-box, key add, optional inverse mix.
// ----------------------------------------------------------------------------
`default_nettype none
module aesd_round (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rkey_i,
  input  wire logic         mix_i,
  output logic      [127:0] state_o
);

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = aesd_pkg::xtime(x);
    end
    return p;
  endfunction

  always_comb begin
    for (int j = 0; j < 16; j++) s[j] = state_i[127 - 8*j -: 8];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4*c] = aesd_pkg::SBOX_INV[s[r + 4*((c + 4 - r) % 4)]]
                     ^ rkey_i[127 - 8*(r + 4*c) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = gm(t[4*c],4'd14) ^ gm(t[4*c+1],4'd11) ^ gm(t[4*c+2],4'd13) ^ gm(t[4*c+3],4'd9);
      m[4*c+1] = gm(t[4*c],4'd9) ^ gm(t[4*c+1],4'd14) ^ gm(t[4*c+2],4'd11) ^ gm(t[4*c+3],4'd13);
      m[4*c+2] = gm(t[4*c],4'd13) ^ gm(t[4*c+1],4'd9) ^ gm(t[4*c+2],4'd14) ^ gm(t[4*c+3],4'd11);
      m[4*c+3] = gm(t[4*c],4'd11) ^ gm(t[4*c+1],4'd13) ^ gm(t[4*c+2],4'd9) ^ gm(t[4*c+3],4'd14);
    end
    for (int j = 0; j < 16; j++) state_o[127 - 8*j -: 8] = mix_i ? m[j] : t[j];
  end

endmodule
`default_nettype wire

// File: sv/aesd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module aesd_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 11
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: sv/aes128_ecb_cbc_decrypt.sv
// ----------------------------------------------------------------------------
// AES-128 ECB/CBC decryptor
// Iterative inverse cipher with round keys held in a small RAM.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tdata: ct_high, ct_low; tuser: first_block; tlast
// out_    | out | tdata: pt_high, pt_low; tlast (end_mark)
// cfg_    | in  | APB registers at 8*i
// out_tvalid rises once the accepted block has had one key-10 add and ten
// inverse rounds through the shared round unit. After the result handshake
// the sequencer returns to idle, where the next request is taken.
// Key writes run a round-key expansion, one round key per cycle, during which
// in_tready is low; the same happens once after reset.
// out_tvalid holds until out_tready; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module aes128_ecb_cbc_decrypt (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // ct_high[63:0], ct_low[127:64]
  input  wire logic         in_tuser,   // first_block
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [127:0] out_tdata,  // pt_high[63:0], pt_low[127:64]
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [5:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic      [63:0]  cfg_prdata,
  output logic              cfg_pready
);

  aesd_pkg::state_t state_r, state_nxt;
  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic         mode_r;
  logic [127:0] prev_r;
  logic [127:0] st_r, st_nxt;
  logic [127:0] ct_r;
  logic [127:0] blk_in;
  logic         first_r, last_r;
  logic [127:0] kw_r, kw_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         kstart_r;
  logic         ram_we;
  logic [3:0]   ram_waddr, ram_raddr;
  logic [127:0] ram_wdata, rkey;
  logic [127:0] rnd_out, pt;
  logic         wr;
  aesd_pkg::reg_idx_t widx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx = aesd_pkg::reg_idx_t'(cfg_paddr[5:3]);
  assign blk_in = {in_tdata[63:0], in_tdata[127:64]};

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      unique case (widx)
        aesd_pkg::REG_KEY_HIGH:   cfg_prdata = key_hi_r;
        aesd_pkg::REG_KEY_LOW:    cfg_prdata = key_lo_r;
        aesd_pkg::REG_IV_HIGH:    cfg_prdata = iv_hi_r;
        aesd_pkg::REG_IV_LOW:     cfg_prdata = iv_lo_r;
        aesd_pkg::REG_CHAIN_MODE: cfg_prdata = {63'd0, mode_r};
        default:                  cfg_prdata = '0;
      endcase
    end
  end

  // next round key word set from current (forward expansion)
  function automatic logic [127:0] knext(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {aesd_pkg::SBOX_FWD[w3[23:16]], aesd_pkg::SBOX_FWD[w3[15:8]],
         aesd_pkg::SBOX_FWD[w3[7:0]], aesd_pkg::SBOX_FWD[w3[31:24]]};
    t = t ^ {aesd_pkg::rcon(r), 24'd0};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  aesd_ram #(.WIDTH(128), .DEPTH(11)) u_rk (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rkey)
  );

  aesd_round u_round (
    .state_i(st_r), .rkey_i(rkey), .mix_i(cnt_r != 4'd0), .state_o(rnd_out)
  );

  assign pt = st_r ^ (mode_r ? (first_r ? {iv_hi_r, iv_lo_r} : prev_r) : 128'd0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    kw_nxt    = kw_r;
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = kw_r;
    ram_raddr = cnt_r;
    in_tready = 1'b0;
    unique case (state_r)
      aesd_pkg::ST_IDLE: begin
        in_tready = !kstart_r;
        ram_raddr = 4'd10;
        if (kstart_r) begin
          state_nxt = aesd_pkg::ST_KEXP;
          kw_nxt = {key_hi_r, key_lo_r};
          cnt_nxt = 4'd0;
        end else if (in_tvalid) begin
          state_nxt = aesd_pkg::ST_ROUND;
          st_nxt = blk_in;
          cnt_nxt = 4'd10;
        end
      end
      aesd_pkg::ST_KEXP: begin
        ram_we = 1'b1;
        kw_nxt = knext(kw_r, cnt_r + 4'd1);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd10) state_nxt = aesd_pkg::ST_IDLE;
      end
      aesd_pkg::ST_ROUND: begin
        // first pass adds round key 10; rkey holds key cnt_r
        ram_raddr = cnt_r - 4'd1;
        if (cnt_r == 4'd10) begin
          st_nxt = st_r ^ rkey;
          cnt_nxt = 4'd9;
        end else if (cnt_r == 4'd0) begin
          st_nxt = rnd_out;
          ram_raddr = 4'd10;
          state_nxt = aesd_pkg::ST_OUT;
        end else begin
          st_nxt = rnd_out;
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      aesd_pkg::ST_OUT: begin
        if (out_tready) state_nxt = aesd_pkg::ST_IDLE;
      end
      default: state_nxt = aesd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= aesd_pkg::ST_IDLE;
      kstart_r <= 1'b1;
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
      mode_r   <= 1'b0;
      prev_r   <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == aesd_pkg::ST_IDLE && kstart_r) kstart_r <= 1'b0;
      if (wr && cfg_paddr[2:0] == 3'd0) begin
        unique case (widx)
          aesd_pkg::REG_KEY_HIGH: begin key_hi_r <= cfg_pwdata; kstart_r <= 1'b1; end
          aesd_pkg::REG_KEY_LOW:  begin key_lo_r <= cfg_pwdata; kstart_r <= 1'b1; end
          aesd_pkg::REG_IV_HIGH:  iv_hi_r <= cfg_pwdata;
          aesd_pkg::REG_IV_LOW:   iv_lo_r <= cfg_pwdata;
          aesd_pkg::REG_CHAIN_MODE: mode_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (state_r == aesd_pkg::ST_OUT && out_tready) prev_r <= ct_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    kw_r <= kw_nxt;
    if (in_tvalid && in_tready) begin
      ct_r    <= blk_in;
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  assign out_tvalid = (state_r == aesd_pkg::ST_OUT);
  assign out_tdata  = {pt[63:0], pt[127:64]};
  assign out_tlast  = last_r;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, !(in_tready && state_r != aesd_pkg::ST_IDLE))
  `ASSERT_NEXT(a_kexp_done, clk, rst_n, state_r == aesd_pkg::ST_KEXP && cnt_r == 4'd10, state_r == aesd_pkg::ST_IDLE)

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 ECB/CBC decryptor testbench
// Streams ciphertext requests through the decryptor under several keys, IVs
// and chaining modes, predicts each plaintext block with a behavioral inverse
// cipher and compares every returned block against it in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;

  typedef struct {
    logic [63:0] ct_hi;
    logic [63:0] ct_lo;
    logic        first;
    logic        last;
  } cipher_req_t;

  typedef struct {
    logic [63:0] pt_hi;
    logic [63:0] pt_lo;
    logic        last;
  } plain_blk_t;

  localparam logic [7:0] RCON_TAB [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                          8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
  localparam int IDLE_PCT = 28;
  localparam int STALL_LIMIT = 4000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // ct_high[63:0], ct_low[127:64]
  logic         in_tuser = 1'b0; // first_block
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // pt_high[63:0], pt_low[127:64]
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [5:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  aes128_ecb_cbc_decrypt DUT (.*);

  always #2 clk = ~clk;

  cipher_req_t pending_reqs[$];
  plain_blk_t  expected_pt[$];
  int          errors = 0;
  logic        calm = 1'b0;
  int          stall_cnt = 0;

  logic [63:0]  key_hi_m, key_lo_m, iv_hi_m, iv_lo_m;
  logic         cbc_m;
  logic [127:0] prev_ct_m;
  logic [127:0] rkeys [11];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  task automatic expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    w[0] = key_hi_m[63:32]; w[1] = key_hi_m[31:0];
    w[2] = key_lo_m[63:32]; w[3] = key_lo_m[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aesd_pkg::SBOX_FWD[t[31:24]], aesd_pkg::SBOX_FWD[t[23:16]],
             aesd_pkg::SBOX_FWD[t[15:8]], aesd_pkg::SBOX_FWD[t[7:0]]};
        t[31:24] ^= RCON_TAB[i/4 - 1];
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] inv_cipher(input logic [127:0] ct);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] res;
    for (int j = 0; j < 16; j++) s[j] = ct[127-8*j -: 8] ^ rkeys[10][127-8*j -: 8];
    for (int r = 9; r >= 0; r--) begin
      for (int rw = 0; rw < 4; rw++)
        for (int c = 0; c < 4; c++)
          t[rw+4*c] = aesd_pkg::SBOX_INV[s[rw + 4*((c+4-rw) % 4)]];
      for (int j = 0; j < 16; j++) s[j] = t[j] ^ rkeys[r][127-8*j -: 8];
      if (r > 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
          s[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
          s[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
          s[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
        end
      end
    end
    for (int j = 0; j < 16; j++) res[127-8*j -: 8] = s[j];
    return res;
  endfunction

  task automatic predict_plain(input cipher_req_t rq);
    logic [127:0] ct, pt;
    plain_blk_t   e;
    ct = {rq.ct_hi, rq.ct_lo};
    pt = inv_cipher(ct);
    if (cbc_m) pt ^= rq.first ? {iv_hi_m, iv_lo_m} : prev_ct_m;
    prev_ct_m = ct;
    e.pt_hi = pt[127:64];
    e.pt_lo = pt[63:0];
    e.last = rq.last;
    expected_pt.push_back(e);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  cipher_req_t nxt_req;

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_plain('{in_tdata[63:0], in_tdata[127:64], in_tuser, in_tlast});
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {nxt_req.ct_lo, nxt_req.ct_hi};
          in_tuser <= nxt_req.first;
          in_tlast <= nxt_req.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  plain_blk_t exp_blk;

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pt.size() == 0) begin
          report("unexpected block", out_tdata[63:0], '0);
        end else begin
          exp_blk = expected_pt.pop_front();
          if (out_tdata[63:0] !== exp_blk.pt_hi) report("pt_high", out_tdata[63:0], exp_blk.pt_hi);
          if (out_tdata[127:64] !== exp_blk.pt_lo) report("pt_low", out_tdata[127:64], exp_blk.pt_lo);
          if (out_tlast !== exp_blk.last) report("end_mark", 64'(out_tlast), 64'(exp_blk.last));
        end
      end
      out_tready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        stall_cnt <= 0;
      else if (stall_cnt >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else
        stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic cfg_write(input aesd_pkg::reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      aesd_pkg::REG_KEY_HIGH:   begin key_hi_m = val; expand_round_keys(); end
      aesd_pkg::REG_KEY_LOW:    begin key_lo_m = val; expand_round_keys(); end
      aesd_pkg::REG_IV_HIGH:    iv_hi_m = val;
      aesd_pkg::REG_IV_LOW:     iv_lo_m = val;
      aesd_pkg::REG_CHAIN_MODE: cbc_m = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk); while (pending_reqs.size() > 0 || in_tvalid || expected_pt.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic push_req(input logic [63:0] hi, input logic [63:0] lo,
                          input logic first, input logic last);
    pending_reqs.push_back('{hi, lo, first, last});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic push_messages(input int n_blocks);
    int len, k;
    k = 0;
    while (k < n_blocks) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len && k < n_blocks; i++, k++) begin
        if ($urandom_range(9) == 0)
          push_req(pick64(), pick64(), $urandom_range(1), $urandom_range(1));
        else
          push_req(pick64(), pick64(), i == 0, i == len - 1);
      end
    end
  endtask

  initial begin
    key_hi_m = '0; key_lo_m = '0; iv_hi_m = '0; iv_lo_m = '0;
    cbc_m = 1'b0; prev_ct_m = '0;
    expand_round_keys();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // chaining straight after reset, zero key
    cfg_write(aesd_pkg::REG_CHAIN_MODE, 64'd1);
    push_req(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0);
    push_req('0, '0, 1'b1, 1'b0);
    push_req('1, '1, 1'b0, 1'b1);
    push_req('1, '0, 1'b1, 1'b1);
    drain();

    // standard test vector, codebook mode with stray flags
    cfg_write(aesd_pkg::REG_CHAIN_MODE, 64'd0);
    cfg_write(aesd_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    cfg_write(aesd_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    push_req(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1, 1'b1);
    push_req(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0, 1'b0);
    push_req('0, '1, 1'b1, 1'b0);
    push_req('1, '0, 1'b0, 1'b1);
    drain();

    // all-ones key and IV, chaining
    cfg_write(aesd_pkg::REG_KEY_HIGH, '1);
    cfg_write(aesd_pkg::REG_KEY_LOW, '1);
    cfg_write(aesd_pkg::REG_IV_HIGH, '1);
    cfg_write(aesd_pkg::REG_IV_LOW, '1);
    cfg_write(aesd_pkg::REG_CHAIN_MODE, 64'd1);
    push_req(rand64(), rand64(), 1'b1, 1'b0);
    push_req(rand64(), rand64(), 1'b0, 1'b0);
    push_req('0, '0, 1'b0, 1'b0);
    push_req('1, '1, 1'b0, 1'b1);
    push_req(64'h8000000000000000, 64'h1, 1'b1, 1'b1);
    drain();

    // mode change in the middle of a message
    cfg_write(aesd_pkg::REG_CHAIN_MODE, 64'd0);
    push_req(rand64(), rand64(), 1'b1, 1'b0);
    drain();
    cfg_write(aesd_pkg::REG_CHAIN_MODE, 64'd1);
    push_req(rand64(), rand64(), 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      if ($urandom_range(1)) cfg_write(aesd_pkg::REG_KEY_HIGH, pick64());
      if ($urandom_range(1)) cfg_write(aesd_pkg::REG_KEY_LOW, pick64());
      cfg_write(aesd_pkg::REG_IV_HIGH, pick64());
      cfg_write(aesd_pkg::REG_IV_LOW, pick64());
      cfg_write(aesd_pkg::REG_CHAIN_MODE, (ph % 4 == 1) ? 64'd0 : 64'd1);
      push_messages(200);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
